[rtl/core/itda_pkg.sv]
// Shared types and constants for the integer to decimal text converter.
package itda_pkg;

  localparam int unsigned DIGIT_W = 4;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } itda_state_e;

  // Per-cycle command broadcast to every digit cell.
  typedef struct packed {
    logic clr;     // load zero
    logic dabble;  // add-3 correction then shift in one binary bit
    logic shift;   // take the neighbor's digit (move toward the top cell)
  } itda_cell_ctrl_t;

endpackage

[rtl/core/itda_cell.sv]
// One BCD digit cell of the double-dabble chain.
module itda_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itda_pkg::itda_cell_ctrl_t     ctrl_i,
  input  logic                          bin_i,
  input  logic [itda_pkg::DIGIT_W-1:0]  dig_i,
  output logic                          bin_o,
  output logic [itda_pkg::DIGIT_W-1:0]  dig_o
);
  import itda_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  // A digit of five or more carries into the next decade after the shift.
  assign adj   = (digit_q >= DIGIT_W'(5)) ? (digit_q + DIGIT_W'(3)) : digit_q;
  assign bin_o = adj[DIGIT_W-1];
  assign dig_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[DIGIT_W-2:0], bin_i};
    end else if (ctrl_i.shift) begin
      digit_d = dig_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  a_digit_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= DIGIT_MAX)
    else $error("digit cell holds a non-decimal value");

  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr |=> digit_q == '0)
    else $error("digit cell did not clear");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctrl_i.clr, ctrl_i.dabble, ctrl_i.shift}) <= 1)
    else $error("digit cell got conflicting commands");

endmodule

[rtl/core/int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII text over a chain of BCD digit cells.
//
// Usage: present a two's complement word on value_i and raise start while busy
// is low; the word is taken at that clock edge and busy rises on the next cycle.
// The magnitude is then shifted MSB first into a row of BCD digit cells, one bit
// per cycle, each cell applying the add-3 correction. For a negative word the
// sign state then emits '-'. The digits are then shifted out of the top cell,
// one per cycle, with leading zeros skipped silently. Each character word
// appears on char_code_o/last_o for exactly one cycle with out_valid_o high,
// registered from the top cell as its digit is shifted out; last_o marks the
// final digit. Zero gives a single '0'.
// Restart: a new word is taken only once the block is idle again, after the
// bit-serial conversion through the cell chain, the sign state and the digit
// shift-out pass of the previous word.
// Reset clears the sequencer, the cells and the output strobe; the block is then
// idle. The receiver cannot stall: every word is taken in the cycle it is shown.
module int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  output logic [7:0]                   char_code_o,
  output logic                         last_o
);
  import itda_pkg::*;

  localparam int unsigned NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  itda_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [VALUE_BITS-1:0] val_u;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  lead_q, lead_d;

  logic                  valid_q, valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  itda_cell_ctrl_t       cell_ctrl;
  logic [NDIG:0]         bin_c;
  logic [DIGIT_W-1:0]    dig_c  [NDIG];
  logic [DIGIT_W-1:0]    dig_in [NDIG];
  logic [DIGIT_W-1:0]    top_dig;
  logic                  accept;
  logic                  emit;

  assign accept  = start && !busy;
  assign val_u   = value_i;
  assign top_dig = dig_c[NDIG-1];
  assign bin_c[0] = mag_q[VALUE_BITS-1];

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign dig_in[i] = '0;
    end else begin : g_rest
      assign dig_in[i] = dig_c[i-1];
    end
    itda_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .bin_i  (bin_c[i]),
      .dig_i  (dig_in[i]),
      .bin_o  (bin_c[i+1]),
      .dig_o  (dig_c[i])
    );
  end

  // Leading zeros are dropped, but the final digit always goes out.
  assign emit = lead_q || (top_dig != '0) || (cnt_q == CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_q == CNT_W'(1)) state_d = neg_q ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    busy      = (state_q != ST_IDLE);
    cell_ctrl = '0;
    mag_d     = mag_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    lead_d    = lead_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cell_ctrl.clr = 1'b1;
          neg_d = val_u[VALUE_BITS-1];
          mag_d = val_u[VALUE_BITS-1] ? (~val_u + VALUE_BITS'(1)) : val_u;
          cnt_d = CNT_W'(VALUE_BITS);
        end
      end
      ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          cnt_d  = CNT_W'(NDIG);
          lead_d = 1'b0;
        end
      end
      ST_SIGN: begin
        valid_d = 1'b1;
        char_d  = CH_MINUS;
        last_d  = 1'b0;
      end
      ST_EMIT: begin
        cell_ctrl.shift = 1'b1;
        cnt_d   = cnt_q - CNT_W'(1);
        valid_d = emit;
        char_d  = CH_ZERO + {{(8-DIGIT_W){1'b0}}, top_dig};
        last_d  = (cnt_q == CNT_W'(1));
        if (emit) lead_d = 1'b1;
      end
      default: begin
        cell_ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      lead_q  <= 1'b0;
      neg_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lead_q  <= lead_d;
      neg_q   <= neg_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CH_MINUS) ||
                    ((char_code_o >= CH_ZERO) && (char_code_o <= CH_NINE)))
    else $error("emitted word is not a sign or a digit");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (char_code_o == CH_MINUS)) |-> !last_o)
    else $error("minus sign flagged as last character");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !bin_c[NDIG])
    else $error("digit chain overflowed during conversion");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cnt_q == CNT_W'(1)) |=> (out_valid_o && last_o))
    else $error("final digit was not emitted with last");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the integer to decimal ASCII text converter.
module tb_top;
  import itda_pkg::*;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned N_RANDOM   = 360;
  localparam int unsigned CYCLE_CAP  = 400_000;
  localparam int unsigned DRAIN_WAIT = 60;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Spells each accepted value as decimal text and checks the emitted characters.
  class decimal_text_sb;
    text_char_t  expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_value(logic signed [VALUE_W-1:0] v);
      logic [VALUE_W:0] mag;
      logic [7:0]       digits[$];
      text_char_t       c;
      // Negate in one extra bit so the most negative value keeps its full magnitude.
      mag = v[VALUE_W-1] ? ((VALUE_W+1)'(0) - {v[VALUE_W-1], v}) : {1'b0, v};
      if (mag == 0) begin
        c.code = CH_ZERO;
        c.last = 1'b1;
        expected_chars.push_back(c);
        return;
      end
      while (mag != 0) begin
        digits.push_front(CH_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end
      if (v[VALUE_W-1]) begin
        c.code = CH_MINUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.code = digits[i];
        c.last = (i == digits.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        $error("character word 0x%02h (last %0b) with nothing expected", code, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $error("char_code: expected 0x%02h, got 0x%02h", want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic [7:0]                char_code_o;
  logic                      last_o;

  decimal_text_sb text_sb = new();
  int unsigned    cycle_count = 0;

  int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      text_sb.check_char(char_code_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Mostly back-to-back or short gaps, with the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 60);
  endfunction

  // Spreads values over every digit count, the signs and the range extremes.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    int unsigned               k;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 200)) - 100;
      3: begin
        v = 1;
        k = $urandom_range(0, 9);
        repeat (k) v = v * 10;
        v = v + $signed($urandom_range(0, 2)) - 1;
      end
      4: v = $urandom >> $urandom_range(0, 31);
      5: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $signed($urandom_range(0, 3))
                                  : 32'sh8000_0000 + $signed($urandom_range(0, 3));
      default: v = $urandom_range(0, 99_999);
    endcase
    if (v > 0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_word(input logic signed [VALUE_W-1:0] v, input int unsigned gap);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    text_sb.note_value(v);
    if (gap != 0) begin
      start   <= 1'b0;
      value_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  logic signed [VALUE_W-1:0] directed_values[$];

  initial begin
    start   = 1'b0;
    value_i = '0;
    rst_ni  = 1'b0;
    directed_values = '{0, 1, -1, 9, -9, 10, -10, 12, -21, 99, 100, -100,
                        1000000000, -1000000000, 999999999, -999999999,
                        1234567890, -1234567890, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        32'sh8000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 7};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) begin
      send_word(directed_values[i], (i % 3 == 0) ? 0 : i % 5);
    end

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      // Let the pipeline drain completely once, then restart from idle.
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        do @(posedge clk_i); while (text_sb.expected_chars.size() != 0);
      end
      // The first stretch runs without any idling on the input side.
      send_word(pick_value(), (n < 40) ? 0 : pick_gap());
    end

    start <= 1'b0;
    do @(posedge clk_i); while (text_sb.expected_chars.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (text_sb.mismatches == 0 && text_sb.expected_chars.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
